// ===== design/afr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afr_pkg
// Shared types and constants for the addressed frame receiver.
// ----------------------------------------------------------------------------
package afr_pkg;

    localparam int unsigned AddrWidth  = 3;
    localparam int unsigned DataWidth  = 32;

    localparam logic [15:0] NodeAddressReset   = 16'hA1E2;
    localparam logic [7:0]  PayloadCutoffReset = 8'd5;

    // register index, taken from paddr[2]
    typedef enum logic {
        REG_NODE_ADDRESS   = 1'b0,
        REG_PAYLOAD_CUTOFF = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic [15:0] node_address;
        logic [7:0]  payload_cutoff;
    } cfg_t;

    typedef struct packed {
        logic       payload_valid;
        logic [7:0] payload_index;
        logic [7:0] payload_byte;
        logic       frame_done;
        logic       frame_aborted;
        logic       frame_start;
        logic [7:0] announced_length;
    } result_t;

endpackage
`default_nettype wire

// ===== design/afr_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afr_cfg_regs
// APB register file: node address and payload cutoff.
// ----------------------------------------------------------------------------
module afr_cfg_regs (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [afr_pkg::AddrWidth-1:0]  paddr,
    input  wire logic [afr_pkg::DataWidth-1:0]  pwdata,
    output logic      [afr_pkg::DataWidth-1:0]  prdata,
    output logic                                pready,
    output afr_pkg::cfg_t                       cfg
);
    import afr_pkg::*;

    logic [15:0] node_address_reg;
    logic [7:0]  payload_cutoff_reg;
    logic        wr_en;
    reg_index_t  sel;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign sel    = reg_index_t'(paddr[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_address_reg   <= NodeAddressReset;
            payload_cutoff_reg <= PayloadCutoffReset;
        end else if (wr_en) begin
            unique case (sel)
                REG_NODE_ADDRESS:   node_address_reg   <= pwdata[15:0];
                REG_PAYLOAD_CUTOFF: payload_cutoff_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (sel)
            REG_NODE_ADDRESS:   prdata = {16'd0, node_address_reg};
            REG_PAYLOAD_CUTOFF: prdata = {24'd0, payload_cutoff_reg};
            default:            prdata = '0;
        endcase
    end

    assign cfg.node_address   = node_address_reg;
    assign cfg.payload_cutoff = payload_cutoff_reg;

endmodule
`default_nettype wire

// ===== design/afr_in_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afr_in_stage
// Input register for received bytes; refills in the cycle it drains.
// ----------------------------------------------------------------------------
module afr_in_stage (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_rx_byte,
    output logic            in_valid,
    output logic      [7:0] in_byte,
    input  wire logic       in_take
);
    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    assign s_ready = !valid_reg || in_take;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (in_take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_rx_byte;
        end
    end

    assign in_valid = valid_reg;
    assign in_byte  = byte_reg;

endmodule
`default_nettype wire

// ===== design/afr_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afr_core
// Frame state, payload/start decode and the result register.
// ----------------------------------------------------------------------------
module afr_core (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire afr_pkg::cfg_t  cfg,
    input  wire logic           in_valid,
    input  wire logic [7:0]     in_byte,
    output logic                in_take,
    output logic                out_valid,
    input  wire logic           out_ready,
    output afr_pkg::result_t    out_result
);
    import afr_pkg::*;

    logic [15:0] window_reg, window_next;
    logic        open_reg, open_next;
    logic [7:0]  count_reg, count_next;
    logic [7:0]  exp_len_reg, exp_len_next;
    logic        out_valid_reg, out_valid_next;
    result_t     result_reg, result_next;
    logic [7:0]  count_inc;
    logic        match;

    assign in_take   = in_valid && (!out_valid_reg || out_ready);
    assign count_inc = count_reg + 8'd1;
    assign match     = (window_reg == cfg.node_address);

    always_comb begin
        result_next  = '0;
        open_next    = open_reg;
        count_next   = count_reg;
        exp_len_next = exp_len_reg;

        if (open_reg) begin
            result_next.payload_valid = 1'b1;
            result_next.payload_index = count_reg;
            result_next.payload_byte  = in_byte;
            count_next                = count_inc;
            // done wins over abort when both hold
            if (count_inc == exp_len_reg) begin
                result_next.frame_done = 1'b1;
                count_next             = '0;
                open_next              = 1'b0;
            end else if (count_inc > cfg.payload_cutoff) begin
                result_next.frame_aborted = 1'b1;
                count_next                = '0;
                open_next                 = 1'b0;
            end
        end

        // address match restarts any frame in progress
        if (match) begin
            result_next.frame_start      = 1'b1;
            result_next.announced_length = in_byte;
            open_next                    = 1'b1;
            exp_len_next                 = in_byte;
            count_next                   = '0;
        end

        window_next = {window_reg[7:0], in_byte};
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (in_take) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg    <= '0;
            open_reg      <= 1'b0;
            count_reg     <= '0;
            exp_len_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (in_take) begin
                window_reg  <= window_next;
                open_reg    <= open_next;
                count_reg   <= count_next;
                exp_len_reg <= exp_len_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            result_reg <= result_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = result_reg;

endmodule
`default_nettype wire

// ===== design/addressed_frame_receiver.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A received byte is held in the input register; its result is then
// registered in the core and driven on the m_ ports. Throughput: one byte
// per cycle unless m_ready stalls; frame state updates in a single pass.
// Reset: synchronous, active low; clears frame state, window and both valid
// flags, and loads node address 0xA1E2 and payload cutoff 5.
// ----------------------------------------------------------------------------
// addressed_frame_receiver
// Byte stream receiver: address match opens a length-prefixed frame whose
// payload bytes are emitted with their index.
// ----------------------------------------------------------------------------
module addressed_frame_receiver (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [afr_pkg::AddrWidth-1:0]  paddr,
    input  wire logic [afr_pkg::DataWidth-1:0]  pwdata,
    output logic      [afr_pkg::DataWidth-1:0]  prdata,
    output logic                                pready,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [7:0]                     s_rx_byte,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic                                m_payload_valid,
    output logic      [7:0]                     m_payload_index,
    output logic      [7:0]                     m_payload_byte,
    output logic                                m_frame_done,
    output logic                                m_frame_aborted,
    output logic                                m_frame_start,
    output logic      [7:0]                     m_announced_length
);
    import afr_pkg::*;

    cfg_t       cfg;
    result_t    result;
    logic       in_valid;
    logic [7:0] in_byte;
    logic       in_take;

    afr_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    afr_in_stage u_in (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .in_valid  (in_valid),
        .in_byte   (in_byte),
        .in_take   (in_take)
    );

    afr_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .in_valid   (in_valid),
        .in_byte    (in_byte),
        .in_take    (in_take),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_result (result)
    );

    assign m_payload_valid    = result.payload_valid;
    assign m_payload_index    = result.payload_index;
    assign m_payload_byte     = result.payload_byte;
    assign m_frame_done       = result.frame_done;
    assign m_frame_aborted    = result.frame_aborted;
    assign m_frame_start      = result.frame_start;
    assign m_announced_length = result.announced_length;

endmodule
`default_nettype wire

// ===== design/afr_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afr_checker
// Port-level checks on the result channel of the frame receiver.
// ----------------------------------------------------------------------------
module afr_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic       m_payload_valid,
    input wire logic [7:0] m_payload_index,
    input wire logic [7:0] m_payload_byte,
    input wire logic       m_frame_done,
    input wire logic       m_frame_aborted,
    input wire logic       m_frame_start,
    input wire logic [7:0] m_announced_length
);

    // stalled transfer keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload_index)
            && $stable(m_payload_byte) && $stable(m_announced_length)
            && $stable(m_frame_start) && $stable(m_payload_valid))
        else $error("result changed while stalled");

    // a frame ends at most one way, and only on a payload byte
    a_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_frame_done || m_frame_aborted) |->
            m_payload_valid && !(m_frame_done && m_frame_aborted))
        else $error("bad frame end flags");

    a_idle_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_payload_valid |->
            m_payload_index == 8'd0 && m_payload_byte == 8'd0)
        else $error("payload fields set without payload");

    // length field is zero unless this byte opened a frame
    a_no_start_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_frame_start |-> m_announced_length == 8'd0)
        else $error("length without frame start");

endmodule

bind addressed_frame_receiver afr_checker u_afr_checker (.*);
`default_nettype wire
